FILE: sv/tsl_pkg.sv
// shared types, constants and helpers for the triangle strip to list block
package tsl_pkg;

	localparam int INDEX_BITS    = 16;
	localparam int VERTEX_BITS   = INDEX_BITS - 1;
	localparam int OUT_BITS      = 15;
	localparam int FIFO_DEPTH    = 4;
	localparam int FIFO_PTR_BITS = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_BITS = $clog2(FIFO_DEPTH + 1);

	typedef struct packed {
		logic [INDEX_BITS-1:0] raw_index;
		logic                  end_of_list;
	} strip_item_t;

	typedef struct packed {
		logic [OUT_BITS-1:0] vertex_first;
		logic [OUT_BITS-1:0] vertex_second;
		logic [OUT_BITS-1:0] vertex_third;
		logic                last_of_run;
	} triangle_t;

	// triangles produced by one index, in output order
	typedef struct packed {
		logic [1:0] count;
		triangle_t  first_tri;
		triangle_t  second_tri;
	} tri_pair_t;

	function automatic logic [OUT_BITS-1:0] to_out(input logic [VERTEX_BITS-1:0] v);
		to_out = OUT_BITS'(v);
	endfunction

endpackage

FILE: sv/tsl_assembler.sv
// strip state (held index, vertex window, winding) and triangle assembly
module tsl_assembler (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  tsl_pkg::strip_item_t item,
	output tsl_pkg::tri_pair_t   pair
);

	localparam logic [1:0] FILL_FULL = 2'd2;

	logic [tsl_pkg::INDEX_BITS-1:0]  held_q, held_n;
	logic                            hv_q, hv_n;
	logic [tsl_pkg::VERTEX_BITS-1:0] older_q, older_n;
	logic [tsl_pkg::VERTEX_BITS-1:0] newer_q, newer_n;
	logic [1:0]                      fill_q, fill_n;
	logic                            cw_q, cw_n;
	logic                            made_a, made_b;
	tsl_pkg::triangle_t              tri_a, tri_b;
	logic [tsl_pkg::VERTEX_BITS-1:0] va, vb;

	assign va = held_q[tsl_pkg::VERTEX_BITS-1:0];
	assign vb = item.raw_index[tsl_pkg::VERTEX_BITS-1:0];

	always_comb begin
		held_n  = held_q;
		hv_n    = hv_q;
		older_n = older_q;
		newer_n = newer_q;
		fill_n  = fill_q;
		cw_n    = cw_q;
		made_a  = 1'b0;
		made_b  = 1'b0;
		tri_a   = '0;
		tri_b   = '0;

		// held index goes in, with the arriving index as its successor
		if (hv_q) begin
			if (held_q[tsl_pkg::INDEX_BITS-1] & item.raw_index[tsl_pkg::INDEX_BITS-1]) begin
				fill_n = '0;
				cw_n   = 1'b1;
			end
			if (fill_n == FILL_FULL) begin
				made_a              = 1'b1;
				tri_a.vertex_first  = cw_n ? tsl_pkg::to_out(older_n) : tsl_pkg::to_out(va);
				tri_a.vertex_second = tsl_pkg::to_out(newer_n);
				tri_a.vertex_third  = cw_n ? tsl_pkg::to_out(va) : tsl_pkg::to_out(older_n);
				cw_n                = !cw_n;
			end else begin
				fill_n = fill_n + 2'd1;
			end
			older_n = newer_n;
			newer_n = va;
		end

		// end of list: arriving index goes straight in, then strip closes
		if (item.end_of_list) begin
			if (fill_n == FILL_FULL) begin
				made_b              = 1'b1;
				tri_b.vertex_first  = cw_n ? tsl_pkg::to_out(older_n) : tsl_pkg::to_out(vb);
				tri_b.vertex_second = tsl_pkg::to_out(newer_n);
				tri_b.vertex_third  = cw_n ? tsl_pkg::to_out(vb) : tsl_pkg::to_out(older_n);
			end
			older_n = newer_n;
			newer_n = vb;
			held_n  = '0;
			hv_n    = 1'b0;
			fill_n  = '0;
			cw_n    = 1'b1;
		end else begin
			held_n = item.raw_index;
			hv_n   = 1'b1;
		end
	end

	always_comb begin
		pair.count                  = {1'b0, made_a} + {1'b0, made_b};
		pair.first_tri              = made_a ? tri_a : tri_b;
		pair.first_tri.last_of_run  = !(made_a && made_b);
		pair.second_tri             = tri_b;
		pair.second_tri.last_of_run = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q  <= '0;
			hv_q    <= 1'b0;
			older_q <= '0;
			newer_q <= '0;
			fill_q  <= '0;
			cw_q    <= 1'b1;
		end else if (en) begin
			held_q  <= held_n;
			hv_q    <= hv_n;
			older_q <= older_n;
			newer_q <= newer_n;
			fill_q  <= fill_n;
			cw_q    <= cw_n;
		end
	end

endmodule

FILE: sv/tsl_tri_fifo.sv
// small output queue taking up to two triangles per cycle, giving one per cycle unless the output stalls
module tsl_tri_fifo (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  tsl_pkg::tri_pair_t                    push,
	output logic [tsl_pkg::FIFO_CNT_BITS-1:0]     free,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output tsl_pkg::triangle_t                    out_data
);

	tsl_pkg::triangle_t                  mem_q [tsl_pkg::FIFO_DEPTH];
	logic [tsl_pkg::FIFO_PTR_BITS-1:0]   rd_q, wr_q, wr_next;
	logic [tsl_pkg::FIFO_CNT_BITS-1:0]   count_q;
	logic                                pop;

	assign out_valid = (count_q != '0);
	assign out_data  = mem_q[rd_q];
	assign pop       = out_valid && !out_stall;
	assign wr_next   = wr_q + tsl_pkg::FIFO_PTR_BITS'(1);
	assign free      = tsl_pkg::FIFO_CNT_BITS'(tsl_pkg::FIFO_DEPTH) - count_q
		+ tsl_pkg::FIFO_CNT_BITS'(pop);

	always_ff @(posedge clk) begin
		if (push.count != 2'd0) begin
			mem_q[wr_q] <= push.first_tri;
		end
		if (push.count == 2'd2) begin
			mem_q[wr_next] <= push.second_tri;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q    <= '0;
			wr_q    <= '0;
			count_q <= '0;
		end else begin
			wr_q    <= wr_q + tsl_pkg::FIFO_PTR_BITS'(push.count);
			rd_q    <= rd_q + tsl_pkg::FIFO_PTR_BITS'(pop);
			count_q <= count_q + tsl_pkg::FIFO_CNT_BITS'(push.count)
				- tsl_pkg::FIFO_CNT_BITS'(pop);
		end
	end

endmodule

FILE: sv/triangle_strip_to_list.sv
// top level: triangle strip indices in, triangle list out
//
// strip channel: one 16-bit index per transaction; two adjacent indices with
//   the top bit set restart the strip, end_of_list closes the index list
// triangle channel: one triangle per transaction, three 15-bit vertices, with
//   last_of_run on the final triangle caused by one index
// an index is held until the next one arrives, so its triangle leaves with
//   the successor; triangle valid rises once the completing index has passed
//   the input register, committed and been written into the output queue
// throughput: one index per cycle while indices make at most one triangle
//   each and the triangle receiver does not stall; an end_of_list index can
//   make two, which leave one at a time through the four-entry output queue
// reset clears the held index, vertex window and fill count, winding starts
//   clockwise and the output queue empties
// when the triangle receiver stalls, triangles collect in the output queue;
//   strip stall rises once the registered index has no room for its results
module triangle_strip_to_list (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 strip_valid,
	output logic                 strip_stall,
	input  tsl_pkg::strip_item_t strip,
	output logic                 triangle_valid,
	input  logic                 triangle_stall,
	output tsl_pkg::triangle_t   triangle
);

	tsl_pkg::strip_item_t              item_s1;
	logic                              valid_s1;
	logic                              advance;
	logic                              accept;
	tsl_pkg::tri_pair_t                pair;
	logic [tsl_pkg::FIFO_CNT_BITS-1:0] free;

	// registered index commits once the queue can take all its triangles
	assign advance     = valid_s1 &&
		(free >= tsl_pkg::FIFO_CNT_BITS'(pair.count));
	assign strip_stall = valid_s1 && !advance;
	assign accept      = strip_valid && !strip_stall;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= strip;
		end
	end

	// strip state and triangle assembly, updated only when the index commits
	tsl_assembler u_assembler (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (advance),
		.item   (item_s1),
		.pair   (pair)
	);

	// result queue; nothing is pushed unless the index commits
	tsl_pkg::tri_pair_t push;
	always_comb begin
		push = pair;
		if (!advance) begin
			push.count = 2'd0;
		end
	end

	tsl_tri_fifo u_tri_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.free      (free),
		.out_valid (triangle_valid),
		.out_stall (triangle_stall),
		.out_data  (triangle)
	);

endmodule
